// ===== rtl/stcm_pkg.sv =====
package stcm_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int MAX_COLOUR_BITS_DEF = 16;
  localparam int LEVEL_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;
  localparam logic [4:0] COLOUR_BITS_RESET = 5'd8;
  localparam logic [6:0] BRIGHTNESS_RESET = 7'd100;
  localparam int PCT_DIV = 100;
  // floor(x/100) = (x * 10737419) >> 30 holds for x < 2^23 here (x <= 65535*100)
  localparam int PCT_RECIP = 10737419;
  localparam int PCT_SHIFT = 30;

  localparam logic CMD_RAMP = 1'b0;
  localparam logic CMD_SPECTRUM = 1'b1;

  typedef struct packed {
    logic command;
    logic signed [VALUE_WIDTH_DEF-1:0] value;
    logic signed [VALUE_WIDTH_DEF-1:0] range_min;
    logic signed [VALUE_WIDTH_DEF-1:0] range_max;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] red_duty;
    logic [LEVEL_W-1:0] green_duty;
    logic [LEVEL_W-1:0] blue_duty;
    logic range_fault;
  } out_word_t;

  // per-channel operation chosen by the front end
  localparam logic [1:0] OP_ZERO = 2'd0;
  localparam logic [1:0] OP_FULL = 2'd1;
  localparam logic [1:0] OP_RISE = 2'd2;
  localparam logic [1:0] OP_FALL = 2'd3;

endpackage

// ===== rtl/stcm_front.sv =====
module stcm_front import stcm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_COLOUR_BITS = MAX_COLOUR_BITS_DEF,
  localparam int DW = VALUE_WIDTH + 1,
  localparam int NW = VALUE_WIDTH + 3
) (
  input  logic clk,
  input  logic rst,
  input  in_word_t in_word,
  input  logic [4:0] colour_bits,
  input  logic [6:0] brightness_percent,
  input  logic in_valid,
  output logic in_ready,
  output logic f_valid,
  input  logic f_ready,
  output logic [MAX_COLOUR_BITS-1:0] f_m,
  output logic [6:0] f_bright,
  output logic [DW-1:0] f_d,
  output logic [NW-1:0] f_n,
  output logic [5:0] f_ops,
  output logic f_fault
);
  logic signed [VALUE_WIDTH-1:0] v, lo, hi, vc;
  logic fault;
  logic [DW-1:0] t, d;
  logic [NW-1:0] s, d1, d2, d3, n;
  logic [1:0] op_r, op_g, op_b;
  logic [4:0] bits;
  logic [6:0] br;

  assign v = VALUE_WIDTH'(in_word.value);
  assign lo = VALUE_WIDTH'(in_word.range_min);
  assign hi = VALUE_WIDTH'(in_word.range_max);

  always_comb begin
    fault = (hi <= lo);
    vc = (v < lo) ? lo : ((v > hi) ? hi : v);
    if (fault) begin
      t = '0;
      d = DW'(1);
    end else begin
      t = DW'({vc[VALUE_WIDTH-1], vc} - {lo[VALUE_WIDTH-1], lo});
      d = DW'({hi[VALUE_WIDTH-1], hi} - {lo[VALUE_WIDTH-1], lo});
    end
    s = {t, 2'b00};
    d1 = NW'(d);
    d2 = {1'b0, d, 1'b0};
    d3 = d1 + d2;
    if (s < d1) begin
      n = s;
      if (in_word.command == CMD_SPECTRUM) begin
        op_r = OP_FALL; op_g = OP_ZERO; op_b = OP_FULL;
      end else begin
        op_r = OP_ZERO; op_g = OP_RISE; op_b = OP_FULL;
      end
    end else if (s < d2) begin
      n = s - d1;
      op_r = OP_ZERO;
      op_g = (in_word.command == CMD_SPECTRUM) ? OP_RISE : OP_FULL;
      op_b = OP_FALL;
    end else if (s < d3) begin
      n = s - d2;
      op_r = OP_RISE; op_g = OP_FULL; op_b = OP_ZERO;
    end else begin
      n = s - d3;
      op_r = OP_FULL; op_g = OP_FALL; op_b = OP_ZERO;
    end
    bits = (colour_bits == 5'd0) ? 5'd1 :
           ((colour_bits > 5'(MAX_COLOUR_BITS)) ? 5'(MAX_COLOUR_BITS) : colour_bits);
    br = (brightness_percent == 7'd0) ? 7'd1 :
         ((brightness_percent > 7'(PCT_DIV)) ? 7'(PCT_DIV) : brightness_percent);
  end

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      f_m <= MAX_COLOUR_BITS'((32'd1 << bits) - 32'd1);
      f_bright <= br;
      f_d <= d;
      f_n <= n;
      f_ops <= {op_r, op_g, op_b};
      f_fault <= fault;
    end
  end
endmodule

// ===== rtl/stcm_fifo.sv =====
module stcm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= wr_data;
  end
endmodule

// ===== rtl/stcm_back.sv =====
module stcm_back import stcm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_COLOUR_BITS = MAX_COLOUR_BITS_DEF,
  localparam int DW = VALUE_WIDTH + 1,
  localparam int NW = VALUE_WIDTH + 3,
  localparam int PW = NW + MAX_COLOUR_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic b_valid,
  output logic b_ready,
  input  logic [MAX_COLOUR_BITS-1:0] b_m,
  input  logic [6:0] b_bright,
  input  logic [DW-1:0] b_d,
  input  logic [NW-1:0] b_n,
  input  logic [5:0] b_ops,
  input  logic b_fault,
  output logic out_valid,
  input  logic out_ready,
  output out_word_t out_word
);
  // stage 0: product; stages 1..PW: restoring divide one quotient bit a stage;
  // then a percent multiply stage, a delay stage and a reciprocal stage.
  localparam int NS = PW + 3;
  logic [NS:0] vld;
  logic adv;
  assign adv = !out_valid || out_ready;
  assign b_ready = adv;

  logic [PW-1:0] num [PW+1];
  logic [PW-1:0] quo [PW+1];
  logic [DW-1:0] rem [PW+1];
  logic [DW-1:0] dv [PW+1];
  logic [MAX_COLOUR_BITS-1:0] mm [PW+1];
  logic [6:0] bb [PW+1];
  logic [5:0] oo [PW+1];
  logic ff [PW+1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-1:0], b_valid};
    if (adv) begin
      num[0] <= PW'(b_n) * PW'(b_m);
      quo[0] <= '0;
      rem[0] <= '0;
      dv[0] <= b_d;
      mm[0] <= b_m;
      bb[0] <= b_bright;
      oo[0] <= b_ops;
      ff[0] <= b_fault;
    end
  end

  for (genvar i = 0; i < PW; i++) begin : g_div
    logic [DW:0] tr;
    logic ge;
    assign tr = {rem[i], num[i][PW-1-i]};
    assign ge = tr >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? DW'(tr - {1'b0, dv[i]}) : tr[DW-1:0];
        quo[i+1] <= quo[i] | (PW'(ge) << (PW-1-i));
        num[i+1] <= num[i];
        dv[i+1] <= dv[i];
        mm[i+1] <= mm[i];
        bb[i+1] <= bb[i];
        oo[i+1] <= oo[i];
        ff[i+1] <= ff[i];
      end
    end
  end

  function automatic logic [LEVEL_W-1:0] lvl(input logic [1:0] op,
      input logic [MAX_COLOUR_BITS-1:0] m, input logic [PW-1:0] q, input logic rz);
    logic [PW-1:0] c;
    c = q + PW'(rz);
    case (op)
      OP_ZERO: lvl = '0;
      OP_FULL: lvl = LEVEL_W'(m);
      OP_RISE: lvl = LEVEL_W'(q);
      OP_FALL: lvl = LEVEL_W'(PW'(m) - c);
      default: lvl = '0;
    endcase
  endfunction

  logic rnz;
  logic [LEVEL_W-1:0] lr, lg, lb;
  assign rnz = (rem[PW] != '0);
  assign lr = lvl(oo[PW][5:4], mm[PW], quo[PW], rnz);
  assign lg = lvl(oo[PW][3:2], mm[PW], quo[PW], rnz);
  assign lb = lvl(oo[PW][1:0], mm[PW], quo[PW], rnz);

  logic [LEVEL_W-1:0] s1r, s1g, s1b;
  logic [22:0] p1r, p1g, p1b;
  logic f1, f2;
  logic [LEVEL_W-1:0] s2r, s2g, s2b;
  logic [22:0] p2r, p2g, p2b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1r <= lr; s1g <= lg; s1b <= lb; f1 <= ff[PW];
      p1r <= 23'(lr) * 23'(bb[PW]);
      p1g <= 23'(lg) * 23'(bb[PW]);
      p1b <= 23'(lb) * 23'(bb[PW]);
      s2r <= s1r; s2g <= s1g; s2b <= s1b; f2 <= f1;
      p2r <= p1r; p2g <= p1g; p2b <= p1b;
    end
  end

  function automatic logic [LEVEL_W-1:0] pct(input logic [22:0] x);
    logic [47:0] y;
    y = 48'(x) * 48'(PCT_RECIP);
    pct = LEVEL_W'(y >> PCT_SHIFT);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.red_level <= s2r;
      out_word.green_level <= s2g;
      out_word.blue_level <= s2b;
      out_word.red_duty <= pct(p2r);
      out_word.green_duty <= pct(p2g);
      out_word.blue_duty <= pct(p2b);
      out_word.range_fault <= f2;
    end
  end
  assign out_valid = vld[NS];
endmodule

// ===== rtl/scalar_to_rgb_colour_map.sv =====
// Path from input acceptance to out_valid: front register, queue, product stage,
// VALUE_WIDTH+3+MAX_COLOUR_BITS divide stages, two duty stages, output register.
// Throughput: one word per cycle while the receiver holds out_ready high; the
// bit-serial divider is fully pipelined, and the back pipe stalls as a whole.
// Reset (rst, synchronous, active high) empties the pipe and queue and sets
// colour_bits to 8 and brightness_percent to 100.
module scalar_to_rgb_colour_map import stcm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_COLOUR_BITS = MAX_COLOUR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_word_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output out_word_t out_word,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int DW = VALUE_WIDTH + 1;
  localparam int NW = VALUE_WIDTH + 3;
  localparam int QW = MAX_COLOUR_BITS + 7 + DW + NW + 6 + 1;

  logic [4:0] colour_bits;
  logic [6:0] brightness_percent;

  // hold the two configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_bits <= COLOUR_BITS_RESET;
      brightness_percent <= BRIGHTNESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOUR_BITS: colour_bits <= cfg_data[4:0];
        REG_BRIGHTNESS: brightness_percent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready;
  logic [MAX_COLOUR_BITS-1:0] f_m;
  logic [6:0] f_bright;
  logic [DW-1:0] f_d;
  logic [NW-1:0] f_n;
  logic [5:0] f_ops;
  logic f_fault;

  // classify: clamp, find the quarter segment and per-channel operation
  stcm_front #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_COLOUR_BITS(MAX_COLOUR_BITS)) u_front (
    .clk, .rst, .in_word, .colour_bits, .brightness_percent,
    .in_valid, .in_ready, .f_valid, .f_ready,
    .f_m, .f_bright, .f_d, .f_n, .f_ops, .f_fault
  );

  logic q_valid, q_ready;
  logic [QW-1:0] q_data;
  logic [MAX_COLOUR_BITS-1:0] b_m;
  logic [6:0] b_bright;
  logic [DW-1:0] b_d;
  logic [NW-1:0] b_n;
  logic [5:0] b_ops;
  logic b_fault;

  // short queue decouples classification from the divider pipe
  stcm_fifo #(.WIDTH(QW)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_m, f_bright, f_d, f_n, f_ops, f_fault}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );
  assign {b_m, b_bright, b_d, b_n, b_ops, b_fault} = q_data;

  // execute: n*M/d divide, round per direction, scale duties
  stcm_back #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_COLOUR_BITS(MAX_COLOUR_BITS)) u_back (
    .clk, .rst, .b_valid(q_valid), .b_ready(q_ready),
    .b_m, .b_bright, .b_d, .b_n, .b_ops, .b_fault,
    .out_valid, .out_ready, .out_word
  );
endmodule

// ===== rtl/stcm_checker.sv =====
module stcm_checker import stcm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_word_t out_word
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word)) else $error("out hold");
  a_fault_colour: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.range_fault |-> out_word.green_level == '0) else $error("fault");
  a_duty_le: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.red_duty <= out_word.red_level) else $error("duty");
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid) else $error("rst");
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready) else $error("rst ready");
endmodule

bind scalar_to_rgb_colour_map stcm_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_word
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the scalar to RGB colour map.
// A predictor inside the bench works out the expected colour word for every
// word the block accepts, and a checker compares each output word with the
// oldest expected one, field by field. The test tasks run in turn: directed
// edge cases, register sweeps, random words under several idling phases, and
// a long receiver hold-off that makes the block fill up and stall its input.
module testbench;
  import stcm_pkg::*;

  localparam int DRAIN_CYCLES = 60;   // longer than the pipe takes to empty
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int IN_W = $bits(in_word_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COLOUR_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the two registers, kept raw; saturation is applied when used
  int unsigned colour_bits_raw = COLOUR_BITS_RESET;
  int unsigned brightness_raw = BRIGHTNESS_RESET;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_start = 1'b0;
  int hold_left = 0;

  out_word_t colour_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;

  scalar_to_rgb_colour_map uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out the colour word for one input word at the current register values.
  function automatic out_word_t map_colour(in_word_t w);
    out_word_t o;
    longint unsigned bits, bright, m, t, d, s, r, g, b;
    longint v, lo, hi;
    bits = colour_bits_raw;
    bright = brightness_raw;
    if (bits < 1) bits = 1;
    if (bits > 16) bits = 16;
    if (bright < 1) bright = 1;
    if (bright > 100) bright = 100;
    m = (64'd1 << bits) - 1;
    v = w.value;
    lo = w.range_min;
    hi = w.range_max;
    o = '0;
    if (hi <= lo) begin
      // empty or inverted range: flag it and show the bottom of the scale
      o.range_fault = 1'b1;
      t = 0;
      d = 1;
    end else begin
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      t = v - lo;
      d = hi - lo;
    end
    s = 4 * t;
    // rising terms round down, falling terms round up
    if (s < d) begin
      if (w.command == CMD_SPECTRUM) begin
        r = m - (s * m + d - 1) / d; g = 0; b = m;
      end else begin
        r = 0; g = (s * m) / d; b = m;
      end
    end else if (s < 2 * d) begin
      if (w.command == CMD_SPECTRUM) begin
        r = 0; g = ((s - d) * m) / d; b = m - ((s - d) * m + d - 1) / d;
      end else begin
        r = 0; g = m; b = m - ((s - d) * m + d - 1) / d;
      end
    end else if (s < 3 * d) begin
      r = ((s - 2 * d) * m) / d; g = m; b = 0;
    end else begin
      r = m; g = m - ((s - 3 * d) * m + d - 1) / d; b = 0;
    end
    o.red_level = r[15:0];
    o.green_level = g[15:0];
    o.blue_level = b[15:0];
    o.red_duty = 16'((r * bright) / 100);
    o.green_duty = 16'((g * bright) / 100);
    o.blue_duty = 16'((b * bright) / 100);
    return o;
  endfunction

  // Receiver: stall at random, or hold off entirely for a long stretch on request.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Record expectations at input handshakes, check words at output handshakes,
  // and watch for a stuck pipe.
  always @(posedge clk) begin
    out_word_t want;
    logic [15:0] want_f[7];
    logic [15:0] got_f[7];
    string names[7];
    if (!rst) begin
      if (in_valid && in_ready)
        colour_q.push_back(map_colour(in_word));
      if (out_valid && out_ready) begin
        if (colour_q.size() == 0) begin
          $display("%0t: unexpected colour word %h", $time, out_word);
          mismatches++;
        end else begin
          want = colour_q.pop_front();
          names = '{"red_level", "green_level", "blue_level", "red_duty",
                    "green_duty", "blue_duty", "range_fault"};
          want_f = '{want.red_level, want.green_level, want.blue_level,
                     want.red_duty, want.green_duty, want.blue_duty,
                     16'(want.range_fault)};
          got_f = '{out_word.red_level, out_word.green_level, out_word.blue_level,
                    out_word.red_duty, out_word.green_duty, out_word.blue_duty,
                    16'(out_word.range_fault)};
          foreach (names[i])
            if (want_f[i] !== got_f[i]) begin
              $display("%0t: %s expected %0d, got %0d", $time, names[i],
                       want_f[i], got_f[i]);
              mismatches++;
            end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one word, with a random gap first, and hold it until it is taken.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_map(logic cmd, int v, int lo, int hi);
    in_word_t w;
    w.command = cmd;
    w.value = 16'(v);
    w.range_min = 16'(lo);
    w.range_max = 16'(hi);
    send_word(w);
  endtask

  // Drain the pipe, then write one register while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (colour_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLOUR_BITS)
      colour_bits_raw = data & 32'h1F;
    else
      brightness_raw = data & 32'h7F;
  endtask

  // Mostly well-formed ranges of varied span with the scalar near them,
  // the rest fully random words (many of them inverted ranges).
  function automatic in_word_t random_word();
    in_word_t w;
    int lo, span, v;
    w = in_word_t'(IN_W'({$urandom, $urandom}));
    if ($urandom_range(99) < 75) begin
      span = ($urandom_range(3) == 0) ? $urandom_range(65535, 1)
                                      : $urandom_range(400, 1);
      lo = $urandom_range(65535 - span) - 32768;
      v = lo - 20 + $urandom_range(span + 40);
      w.range_min = 16'(lo);
      w.range_max = 16'(lo + span);
      w.value = 16'(v);
    end
    return w;
  endfunction

  task automatic test_directed_cases();
    int vals[7] = '{-32768, -100, -50, 0, 50, 100, 32767};
    for (int c = 0; c < 2; c++) begin
      foreach (vals[i]) send_map(c[0], vals[i], -100, 100);
      send_map(c[0], 5, 7, 7);              // empty range
      send_map(c[0], 0, 100, -100);         // inverted range
      send_map(c[0], -32768, -32768, 32767);
      send_map(c[0], 32767, -32768, 32767);
    end
    send_map(CMD_SPECTRUM, 32767, 32767, -32768);
  endtask

  task automatic test_register_sweep();
    int unsigned bits_set[7] = '{1, 16, 0, 31, 5, 12, 8};
    int unsigned bright_set[7] = '{1, 100, 127, 0, 37, 50, 100};
    foreach (bits_set[k]) begin
      write_reg(REG_COLOUR_BITS, bits_set[k]);
      write_reg(REG_BRIGHTNESS, bright_set[k]);
      repeat (20) send_word(random_word());
    end
  endtask

  task automatic test_idling_phases();
    int tx_set[4] = '{0, 66, 0, 34};
    int rx_set[4] = '{0, 0, 66, 34};
    int unsigned bits_set[4] = '{16, 3, 10, 8};
    int unsigned bright_set[4] = '{100, 73, 1, 99};
    foreach (tx_set[k]) begin
      write_reg(REG_COLOUR_BITS, bits_set[k]);
      write_reg(REG_BRIGHTNESS, bright_set[k]);
      tx_idle_pct = tx_set[k];
      rx_stall_pct = rx_set[k];
      repeat (80) send_word(random_word());
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 20;
    hold_start = 1'b1;
    repeat (90) send_word(random_word());
    rx_stall_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_sweep();
    test_idling_phases();
    test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    while (colour_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stcm_pkg.sv
rtl/stcm_front.sv
rtl/stcm_fifo.sv
rtl/stcm_back.sv
rtl/scalar_to_rgb_colour_map.sv
rtl/stcm_checker.sv
tb/testbench.sv
